@@ hdl/allocation_record_tracker_defines.svh @@
// Assertion macros shared by the allocation record tracker RTL.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef ALLOCATION_RECORD_TRACKER_DEFINES_SVH
`define ALLOCATION_RECORD_TRACKER_DEFINES_SVH

// Property must hold at every clock edge outside reset.
`define ART_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition must never be true outside reset.
`define ART_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

@@ hdl/art_pkg.sv @@
// Shared types and constants for the allocation record tracker.
// No dependencies; imported by art_table and allocation_record_tracker.
package art_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = IDX_W + 1;

    localparam int ADDR_W  = 48;
    localparam int SIZE_W  = 48;
    localparam int RIDX_W  = 10;
    localparam int LIVE_W  = 11;

    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

    typedef enum logic [1:0] {
        ACT_ALLOC  = 2'd0,
        ACT_FREE   = 2'd1,
        ACT_REPORT = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_MISMATCH  = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    typedef struct packed {
        logic              ent_array;
        logic [SIZE_W-1:0] ent_size;
        logic [ADDR_W-1:0] ent_addr;
    } entry_t;

endpackage

@@ hdl/art_table.sv @@
// Entry storage for the allocation record tracker: one write port and
// one registered read port. Depends on art_pkg.
module art_table (
    input  logic                    clk,
    input  logic                    wr_en,
    input  logic [art_pkg::IDX_W-1:0] wr_idx,
    input  art_pkg::entry_t         wr_data,
    input  logic [art_pkg::IDX_W-1:0] rd_idx,
    output art_pkg::entry_t         rd_data
);
    import art_pkg::*;

    entry_t mem [TABLE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_idx] <= wr_data;
        end
        rd_data <= mem[rd_idx];
    end

endmodule

@@ hdl/allocation_record_tracker.sv @@
// Allocation record tracker: request sequencer, address compare and
// result registers. Depends on art_pkg, art_table and the defines header.
//
// Usage:
//   A request is taken when start is high and busy is low. action selects
//   allocate, free or report; address, alloc_size, array_form and
//   report_index carry the operands. Every request yields one result,
//   shown for one cycle while done is high, with status, live_count and
//   the entry_* fields. The receiver cannot hold results off.
// Sequencing, from acceptance up to the result:
//   null address, unused action, full table, report out of range: the
//   result is set straight from S_IDLE. allocate: S_ALLOC writes the
//   entry. report: S_REPORT takes the table read issued at acceptance.
//   free: S_SEARCH makes one table read per compare until a match or the
//   live entries run out; on a match S_FETCH reads the last entry and
//   S_MOVE moves it into the freed slot. busy drops in the cycle the
//   result is shown, so the next request may be issued then.
// Reset:
//   rst_n clears the live count and the sequencer; table contents are
//   not cleared, and entries at or above the live count are never used.
`include "allocation_record_tracker_defines.svh"

module allocation_record_tracker (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [1:0]                action,
    input  logic [art_pkg::ADDR_W-1:0] address,
    input  logic [art_pkg::SIZE_W-1:0] alloc_size,
    input  logic                      array_form,
    input  logic [art_pkg::RIDX_W-1:0] report_index,
    output logic                      done,
    output logic [1:0]                status,
    output logic [art_pkg::LIVE_W-1:0] live_count,
    output logic [art_pkg::ADDR_W-1:0] entry_address,
    output logic [art_pkg::SIZE_W-1:0] entry_size,
    output logic                      entry_array,
    output logic                      entry_valid
);
    import art_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_ALLOC  = 6'b000010,
        S_SEARCH = 6'b000100,
        S_FETCH  = 6'b001000,
        S_MOVE   = 6'b010000,
        S_REPORT = 6'b100000
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  live_reg, live_next;
    logic [CNT_W-1:0]  scan_reg, scan_next;
    logic              cmp_vld_reg, cmp_vld_next;
    logic [IDX_W-1:0]  cmp_idx_reg, cmp_idx_next;
    logic [IDX_W-1:0]  hit_idx_reg, hit_idx_next;
    logic              mis_reg, mis_next;
    logic              done_reg, done_next;

    logic [ADDR_W-1:0] addr_reg;
    logic [SIZE_W-1:0] size_reg;
    logic              arr_reg;
    status_t           status_reg, status_next;
    entry_t            ent_reg, ent_next;
    logic              ent_vld_reg, ent_vld_next;

    logic              capture;
    logic              tbl_we;
    logic [IDX_W-1:0]  tbl_widx;
    entry_t            tbl_wdata;
    logic [IDX_W-1:0]  tbl_ridx;
    entry_t            tbl_rdata;

    logic [CNT_W-1:0]  last_cnt;
    logic              scan_more;
    logic              addr_hit;

    art_table u_table (
        .clk     (clk),
        .wr_en   (tbl_we),
        .wr_idx  (tbl_widx),
        .wr_data (tbl_wdata),
        .rd_idx  (tbl_ridx),
        .rd_data (tbl_rdata)
    );

    assign last_cnt  = live_reg - 1'b1;
    assign scan_more = (scan_reg < live_reg);
    // the one comparator, fed one table entry per cycle during a search
    assign addr_hit  = cmp_vld_reg && (tbl_rdata.ent_addr == addr_reg);

    always_comb
    begin
        state_next   = state_reg;
        live_next    = live_reg;
        scan_next    = scan_reg;
        cmp_vld_next = 1'b0;
        cmp_idx_next = cmp_idx_reg;
        hit_idx_next = hit_idx_reg;
        mis_next     = mis_reg;
        done_next    = 1'b0;
        status_next  = status_reg;
        ent_next     = ent_reg;
        ent_vld_next = ent_vld_reg;
        capture      = 1'b0;
        tbl_we       = 1'b0;
        tbl_widx     = hit_idx_reg;
        tbl_wdata    = tbl_rdata;
        tbl_ridx     = IDX_W'(report_index);

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    capture      = 1'b1;
                    ent_next     = '0;
                    ent_vld_next = 1'b0;
                    status_next  = ST_OK;
                    case (action)
                        ACT_ALLOC:
                        begin
                            if (address == '0)
                            begin
                                done_next = 1'b1;
                            end
                            else if (live_reg >= DEPTH_CNT)
                            begin
                                done_next   = 1'b1;
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                state_next = S_ALLOC;
                            end
                        end
                        ACT_FREE:
                        begin
                            if (address == '0)
                            begin
                                done_next = 1'b1;
                            end
                            else
                            begin
                                scan_next  = '0;
                                state_next = S_SEARCH;
                            end
                        end
                        ACT_REPORT:
                        begin
                            // read was issued at report_index this cycle
                            if (CNT_W'(report_index) < live_reg)
                            begin
                                state_next = S_REPORT;
                            end
                            else
                            begin
                                done_next = 1'b1;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            S_ALLOC:
            begin
                tbl_we      = 1'b1;
                tbl_widx    = live_reg[IDX_W-1:0];
                tbl_wdata   = '{ent_array: arr_reg, ent_size: size_reg, ent_addr: addr_reg};
                live_next   = live_reg + 1'b1;
                done_next   = 1'b1;
                status_next = ST_OK;
                state_next  = S_IDLE;
            end
            S_SEARCH:
            begin
                tbl_ridx = scan_reg[IDX_W-1:0];
                if (addr_hit)
                begin
                    hit_idx_next = cmp_idx_reg;
                    mis_next     = (tbl_rdata.ent_array != arr_reg);
                    state_next   = S_FETCH;
                end
                else if (scan_more)
                begin
                    cmp_vld_next = 1'b1;
                    cmp_idx_next = scan_reg[IDX_W-1:0];
                    scan_next    = scan_reg + 1'b1;
                end
                else if (!cmp_vld_reg)
                begin
                    done_next   = 1'b1;
                    status_next = ST_NOT_FOUND;
                    state_next  = S_IDLE;
                end
            end
            S_FETCH:
            begin
                tbl_ridx   = last_cnt[IDX_W-1:0];
                state_next = S_MOVE;
            end
            S_MOVE:
            begin
                // last entry moves into the freed slot
                tbl_we      = 1'b1;
                tbl_widx    = hit_idx_reg;
                tbl_wdata   = tbl_rdata;
                live_next   = last_cnt;
                done_next   = 1'b1;
                status_next = mis_reg ? ST_MISMATCH : ST_OK;
                state_next  = S_IDLE;
            end
            S_REPORT:
            begin
                ent_next     = tbl_rdata;
                ent_vld_next = 1'b1;
                done_next    = 1'b1;
                status_next  = ST_OK;
                state_next   = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            live_reg    <= '0;
            scan_reg    <= '0;
            cmp_vld_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            live_reg    <= live_next;
            scan_reg    <= scan_next;
            cmp_vld_reg <= cmp_vld_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (capture)
        begin
            addr_reg <= address;
            size_reg <= alloc_size;
            arr_reg  <= array_form;
        end
        cmp_idx_reg <= cmp_idx_next;
        hit_idx_reg <= hit_idx_next;
        mis_reg     <= mis_next;
        status_reg  <= status_next;
        ent_reg     <= ent_next;
        ent_vld_reg <= ent_vld_next;
    end

    assign busy          = (state_reg != S_IDLE);
    assign done          = done_reg;
    assign status        = status_reg;
    assign live_count    = LIVE_W'(live_reg);
    assign entry_address = ent_reg.ent_addr;
    assign entry_size    = ent_reg.ent_size;
    assign entry_array   = ent_reg.ent_array;
    assign entry_valid   = ent_vld_reg;

    `ART_NEVER(a_live_bound, live_reg > DEPTH_CNT, "live count above table depth")
    `ART_ASSERT(a_done_idle, done_reg |-> state_reg == S_IDLE, "result shown while busy")
    `ART_ASSERT(a_alloc_room, state_reg == S_ALLOC |-> live_reg < DEPTH_CNT, "append into full table")
    `ART_ASSERT(a_move_dec, state_reg == S_MOVE |=> live_reg == $past(last_cnt), "free did not drop count")
    `ART_ASSERT(a_hit_live, state_reg == S_FETCH |-> CNT_W'(hit_idx_reg) < live_reg, "match beyond live entries")

endmodule
